[sv/fcpa_pkg.sv]
// Package for the fixed cell pool allocator.
// Holds shared constants, status and command codes and the channel payload types.
// No dependencies.
package fcpa_pkg;

	localparam int unsigned NumCellsDef    = 256;
	localparam int unsigned HeaderBytesDef = 8;
	localparam int unsigned EndMarkerBytes = 4;
	localparam int unsigned MaxCells       = 256;

	localparam logic [8:0]  PoolCellsRst   = 9'd256;
	localparam logic [15:0] ContentSizeRst = 16'd16;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SIZE    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	localparam logic [0:0] CFG_POOL_CELLS   = 1'b0;
	localparam logic [0:0] CFG_CONTENT_SIZE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
		logic [7:0]  cell_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  granted_index;
		logic [23:0] content_offset;
		logic [8:0]  used_count;
	} rsp_t;

	typedef struct packed {
		logic [0:0]  index;
		logic [15:0] wdata;
	} cfg_t;

endpackage

[sv/fcpa_ifs.sv]
// Valid/ready channel interfaces of the fixed cell pool allocator.
// Depends on fcpa_pkg for the payload types.
interface fcpa_req_if import fcpa_pkg::*;;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fcpa_rsp_if import fcpa_pkg::*;;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fcpa_cfg_if import fcpa_pkg::*;;
	logic valid;
	logic ready;
	cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/fcpa_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module fcpa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

[sv/fixed_cell_pool_allocator_unit.sv]
// Fixed cell pool allocator, top level.
// Uses fcpa_pkg, the channel interfaces in fcpa_ifs and the RAM in fcpa_ram.
// Usage:
//   req : request transactions {cmd, req_size, cell_index}. cmd CMD_ALLOC asks
//         for a cell of content_size bytes, cmd CMD_FREE returns cell_index.
//   rsp : one response transaction per request {status, granted_index,
//         content_offset, used_count}, in request order.
//   cfg : register writes {index, wdata}; index 0 is pool_cells, index 1 is
//         content_size. Always ready; write only while no request is in flight.
// Timing: a request is accepted in the idle state, which launches the reads of
//   the free stack RAM and the allocation map RAM. In the execute state the
//   registered read data is back; once the response register is free the
//   decision is made, the map RAM (and for a free the stack RAM) is written back
//   and the response register is loaded. No new request is taken until then.
// Stall: a response waits in its output register; a request already read holds
//   in the execute state until the response register is free.
// Reset: arst_n clears the counters, the state machine and the response valid,
//   and loads pool_cells 256 and content_size 16. The map RAM needs no clearing:
//   cells at or above the bump pointer read as free, and every cell below it
//   was written when it was first handed out.
module fixed_cell_pool_allocator_unit import fcpa_pkg::*; #(
	parameter int unsigned NUM_CELLS    = NumCellsDef,
	parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	fcpa_req_if.sink   req,
	fcpa_rsp_if.source rsp,
	fcpa_cfg_if.sink   cfg
);

	// Storage covers at most MaxCells cells; the pool limit never exceeds it.
	localparam int unsigned DEPTH = (NUM_CELLS < MaxCells) ? NUM_CELLS : MaxCells;
	localparam int unsigned AW    = $clog2(DEPTH);

	localparam logic [8:0]  CellCap      = 9'(DEPTH);
	localparam logic [17:0] CellOverhead = 18'(HEADER_BYTES + EndMarkerBytes);
	localparam logic [23:0] HeaderOff    = 24'(HEADER_BYTES);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	// Configuration and allocator state
	logic [8:0]  pool_cells_q;
	logic [15:0] content_size_q;
	logic [8:0]  stack_depth_q;
	logic [8:0]  bump_q;
	logic [8:0]  used_q;
	logic        state_q;
	req_t        req_s1;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	// RAM ports
	logic          stk_we;
	logic [AW-1:0] stk_waddr;
	logic [AW-1:0] stk_wdata;
	logic [AW-1:0] stk_rdata;
	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic [0:0]    map_wdata;
	logic [0:0]    map_rdata;

	logic        accept;
	logic        fire;
	logic [8:0]  lim;
	logic [8:0]  pop_ptr;
	logic [8:0]  idx9;
	logic        size_ok;
	logic        have_stack;
	logic        alloc_ok;
	logic        free_ok;
	logic [1:0]  status;
	logic [7:0]  grant;
	logic [17:0] cell_bytes;
	logic [25:0] product;
	logic [23:0] offset;
	logic [8:0]  used_next;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	// Decide only when the response register can take the result.
	assign fire      = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	assign lim     = (pool_cells_q > CellCap) ? CellCap : pool_cells_q;
	assign pop_ptr = stack_depth_q - 9'd1;

	fcpa_ram #(
		.WIDTH (AW),
		.DEPTH (DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.we      (stk_we),
		.waddr   (stk_waddr),
		.wdata   (stk_wdata),
		.re      (accept),
		.raddr   (pop_ptr[AW-1:0]),
		.rdata_q (stk_rdata)
	);

	fcpa_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map_ram (
		.clk     (clk),
		.we      (map_we),
		.waddr   (map_waddr),
		.wdata   (map_wdata),
		.re      (accept),
		.raddr   (req.data.cell_index[AW-1:0]),
		.rdata_q (map_rdata)
	);

	// Decision on the read data of the held request
	always_comb begin
		idx9       = {1'b0, req_s1.cell_index};
		size_ok    = (req_s1.req_size == content_size_q);
		have_stack = (stack_depth_q != 9'd0);
		grant      = have_stack ? 8'(stk_rdata) : bump_q[7:0];
		alloc_ok   = 1'b0;
		free_ok    = 1'b0;
		status     = ST_OK;
		if (req_s1.cmd == CMD_ALLOC) begin
			if (!size_ok) begin
				status = ST_SIZE;
			end else if (used_q >= lim) begin
				status = ST_FULL;
			end else if (!have_stack && (bump_q >= lim)) begin
				status = ST_FULL;
			end else begin
				alloc_ok = 1'b1;
			end
		end else begin
			// A cell at or above the bump pointer was never handed out.
			if ((idx9 < lim) && (idx9 < bump_q) && map_rdata[0]) begin
				free_ok = 1'b1;
			end else begin
				status = ST_BADFREE;
			end
		end

		cell_bytes = 18'(content_size_q) + CellOverhead;
		product    = 26'(grant) * 26'(cell_bytes);
		offset     = product[23:0] + HeaderOff;

		used_next = used_q;
		if (alloc_ok) begin
			used_next = used_q + 9'd1;
		end else if (free_ok && (used_q != 9'd0)) begin
			used_next = used_q - 9'd1;
		end
	end

	// Write back: mark a granted cell, clear and push a freed one.
	always_comb begin
		stk_we    = fire && free_ok && (stack_depth_q < CellCap);
		stk_waddr = stack_depth_q[AW-1:0];
		stk_wdata = req_s1.cell_index[AW-1:0];
		map_we    = fire && (alloc_ok || free_ok);
		map_waddr = alloc_ok ? grant[AW-1:0] : req_s1.cell_index[AW-1:0];
		map_wdata = alloc_ok ? 1'b1 : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cells_q   <= PoolCellsRst;
			content_size_q <= ContentSizeRst;
			stack_depth_q  <= 9'd0;
			bump_q         <= 9'd0;
			used_q         <= 9'd0;
			state_q        <= S_IDLE;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					CFG_POOL_CELLS:   pool_cells_q   <= cfg.data.wdata[8:0];
					CFG_CONTENT_SIZE: content_size_q <= cfg.data.wdata;
					default:          ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (fire) begin
				used_q <= used_next;
				if (alloc_ok && have_stack) begin
					stack_depth_q <= pop_ptr;
				end else if (alloc_ok) begin
					bump_q <= bump_q + 9'd1;
				end else if (free_ok && (stack_depth_q < CellCap)) begin
					stack_depth_q <= stack_depth_q + 9'd1;
				end
			end

			// Hold the response until taken; reload on the next decision.
			rsp_valid_q <= fire || (rsp_valid_q && !rsp.ready);
		end
	end

	// Payload registers: request hold and response
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req.data;
		end
		if (fire) begin
			rsp_q.status         <= status;
			rsp_q.granted_index  <= alloc_ok ? grant : 8'd0;
			rsp_q.content_offset <= alloc_ok ? offset : 24'd0;
			rsp_q.used_count     <= used_next;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
